FILE: src/polygon_area_centroid_assert.svh
// ----------------------------------------------------------------------------
// polygon_area_centroid_assert.svh
// assertion macros shared by the polygon area and centroid modules
// ----------------------------------------------------------------------------
`ifndef POLYGON_AREA_CENTROID_ASSERT_SVH
`define POLYGON_AREA_CENTROID_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property checked on clk, off during reset
`define PAC_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold
`define PAC_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define PAC_CHECK(label, prop, msg)
`define PAC_NEVER(label, cond, msg)

`endif

`endif

FILE: src/pac_pkg.sv
// ----------------------------------------------------------------------------
// pac_pkg
// shared constants and types of the polygon area and centroid block
// ----------------------------------------------------------------------------
package pac_pkg;

	localparam int COORD_BITS  = 13;
	localparam int CROSS_W     = 40;
	localparam int MOMENT_W    = 56;
	localparam int AREA_W      = 28;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [AREA_W-1:0] AREA_MAX = '1;

	// closed polygon sums handed from front to back
	typedef struct packed {
		logic [CROSS_W-1:0]  cs;
		logic [MOMENT_W-1:0] mx;
		logic [MOMENT_W-1:0] my;
		logic                few;
	} pac_sum_t;

endpackage

FILE: src/pac_intf.sv
// ----------------------------------------------------------------------------
// pac_intf
// valid/ready channels for vertex words and result words
// ----------------------------------------------------------------------------
interface pac_vertex_if #(
	parameter int COORD_BITS = pac_pkg::COORD_BITS
) ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] vx;
	logic [COORD_BITS-1:0] vy;
	logic                  last;

	modport source (output valid, output vx, output vy, output last, input ready);
	modport sink (input valid, input vx, input vy, input last, output ready);
endinterface

interface pac_result_if #(
	parameter int COORD_BITS = pac_pkg::COORD_BITS
) ();
	logic                      valid;
	logic                      ready;
	logic [pac_pkg::AREA_W-1:0] area_x2;
	logic [COORD_BITS-1:0]     center_x;
	logic [COORD_BITS-1:0]     center_y;
	logic                      degenerate;

	modport source (output valid, output area_x2, output center_x, output center_y,
		output degenerate, input ready);
	modport sink (input valid, input area_x2, input center_x, input center_y,
		input degenerate, output ready);
endinterface

FILE: src/pac_front.sv
// ----------------------------------------------------------------------------
// pac_front
// vertex intake: edge cross products, moments and running sums; unless a full queue stalls it, one per cycle
// ----------------------------------------------------------------------------
`include "polygon_area_centroid_assert.svh"

module pac_front #(
	parameter int COORD_BITS = pac_pkg::COORD_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	pac_vertex_if.sink        vertex,
	output logic              push,
	output pac_pkg::pac_sum_t push_data,
	input  logic              q_full
);

	localparam int PROD_W = 2 * COORD_BITS;
	localparam int SUM_W  = COORD_BITS + 1;
	localparam int CR_W   = PROD_W + 1;
	localparam int CS_W   = CR_W + 1;
	localparam int MT_W   = SUM_W + CR_W;
	localparam int MS_W   = MT_W + 1;

	typedef logic [COORD_BITS-1:0] coord_t;

	logic   adv;
	logic   accept;
	coord_t first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [1:0] count_q;

	coord_t e1_ax, e1_ay, e1_bx, e1_by;
	coord_t e2_ax, e2_ay, e2_bx, e2_by;
	coord_t cl_x, cl_y;
	logic   e1_on;

	logic v_s1, v_s2, v_s3, v_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic few_s1, few_s2, few_s3, few_s4;

	logic [PROD_W-1:0] p1_s1, p2_s1, p3_s1, p4_s1;
	logic [SUM_W-1:0]  sx1_s1, sy1_s1, sx2_s1, sy2_s1;
	logic [SUM_W-1:0]  sx1_s2, sy1_s2, sx2_s2, sy2_s2;
	logic signed [CR_W-1:0] c1_s2, c2_s2;
	logic signed [MT_W-1:0] mx1_s3, mx2_s3, my1_s3, my2_s3;
	logic signed [CS_W-1:0] cs_s3, cs_s4;
	logic signed [MS_W-1:0] mx_s4, my_s4;

	logic signed [pac_pkg::CROSS_W-1:0]  acc_cs_q, nxt_cs;
	logic signed [pac_pkg::MOMENT_W-1:0] acc_mx_q, acc_my_q, nxt_mx, nxt_my;

	assign adv          = !(v_s4 && last_s4 && q_full);
	assign vertex.ready = adv;
	assign accept       = vertex.valid && adv;

	// edge from previous vertex, and closing edge on the last vertex
	always_comb begin
		e1_on = (count_q != 2'd0);
		cl_x  = (count_q == 2'd0) ? vertex.vx : first_x_q;
		cl_y  = (count_q == 2'd0) ? vertex.vy : first_y_q;
		e1_ax = e1_on ? prev_x_q : '0;
		e1_ay = e1_on ? prev_y_q : '0;
		e1_bx = e1_on ? vertex.vx : '0;
		e1_by = e1_on ? vertex.vy : '0;
		e2_ax = vertex.last ? vertex.vx : '0;
		e2_ay = vertex.last ? vertex.vy : '0;
		e2_bx = vertex.last ? cl_x : '0;
		e2_by = vertex.last ? cl_y : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (accept) begin
			if (vertex.last) begin
				count_q <= 2'd0;
			end else if (count_q != 2'd3) begin
				count_q <= count_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_x_q <= vertex.vx;
			prev_y_q <= vertex.vy;
			if (count_q == 2'd0) begin
				first_x_q <= vertex.vx;
				first_y_q <= vertex.vy;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s1   <= e1_ax * e1_by;
			p2_s1   <= e1_bx * e1_ay;
			p3_s1   <= e2_ax * e2_by;
			p4_s1   <= e2_bx * e2_ay;
			sx1_s1  <= SUM_W'(e1_ax) + SUM_W'(e1_bx);
			sy1_s1  <= SUM_W'(e1_ay) + SUM_W'(e1_by);
			sx2_s1  <= SUM_W'(e2_ax) + SUM_W'(e2_bx);
			sy2_s1  <= SUM_W'(e2_ay) + SUM_W'(e2_by);
			last_s1 <= vertex.last;
			few_s1  <= (count_q < 2'd2);

			c1_s2   <= $signed({1'b0, p1_s1}) - $signed({1'b0, p2_s1});
			c2_s2   <= $signed({1'b0, p3_s1}) - $signed({1'b0, p4_s1});
			sx1_s2  <= sx1_s1;
			sy1_s2  <= sy1_s1;
			sx2_s2  <= sx2_s1;
			sy2_s2  <= sy2_s1;
			last_s2 <= last_s1;
			few_s2  <= few_s1;

			mx1_s3  <= $signed({1'b0, sx1_s2}) * c1_s2;
			mx2_s3  <= $signed({1'b0, sx2_s2}) * c2_s2;
			my1_s3  <= $signed({1'b0, sy1_s2}) * c1_s2;
			my2_s3  <= $signed({1'b0, sy2_s2}) * c2_s2;
			cs_s3   <= CS_W'(c1_s2) + CS_W'(c2_s2);
			last_s3 <= last_s2;
			few_s3  <= few_s2;

			mx_s4   <= MS_W'(mx1_s3) + MS_W'(mx2_s3);
			my_s4   <= MS_W'(my1_s3) + MS_W'(my2_s3);
			cs_s4   <= cs_s3;
			last_s4 <= last_s3;
			few_s4  <= few_s3;
		end
	end

	assign nxt_cs = acc_cs_q + pac_pkg::CROSS_W'(cs_s4);
	assign nxt_mx = acc_mx_q + pac_pkg::MOMENT_W'(mx_s4);
	assign nxt_my = acc_my_q + pac_pkg::MOMENT_W'(my_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_cs_q <= '0;
			acc_mx_q <= '0;
			acc_my_q <= '0;
		end else if (adv && v_s4) begin
			if (last_s4) begin
				acc_cs_q <= '0;
				acc_mx_q <= '0;
				acc_my_q <= '0;
			end else begin
				acc_cs_q <= nxt_cs;
				acc_mx_q <= nxt_mx;
				acc_my_q <= nxt_my;
			end
		end
	end

	assign push          = adv && v_s4 && last_s4;
	assign push_data.cs  = nxt_cs;
	assign push_data.mx  = nxt_mx;
	assign push_data.my  = nxt_my;
	assign push_data.few = few_s4;

	`PAC_CHECK(a_stall_holds_last, (v_s4 && !adv) |=> (v_s4 && last_s4), "stalled closing word lost")
	`PAC_CHECK(a_count_restart, (accept && vertex.last) |=> (count_q == 2'd0), "vertex count not cleared")
	`PAC_NEVER(a_ready_when_full, (v_s4 && last_s4 && q_full && vertex.ready), "ready while queue full")

endmodule

FILE: src/pac_queue.sv
// ----------------------------------------------------------------------------
// pac_queue
// short queue of closed polygon sums between front and back
// ----------------------------------------------------------------------------
`include "polygon_area_centroid_assert.svh"

module pac_queue #(
	parameter int DEPTH = pac_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pac_pkg::pac_sum_t push_data,
	output logic              full,
	input  logic              pop,
	output pac_pkg::pac_sum_t pop_data,
	output logic              empty
);

	localparam int AW    = $clog2(DEPTH);
	localparam int LVL_W = $clog2(DEPTH + 1);

	pac_pkg::pac_sum_t mem_q [DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [LVL_W-1:0]  level_q;

	assign full     = (level_q == LVL_W'(DEPTH));
	assign empty    = (level_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

	`PAC_NEVER(a_no_overflow, (push && full), "push into full queue")
	`PAC_NEVER(a_no_underflow, (pop && empty), "pop from empty queue")
	`PAC_NEVER(a_level_bound, (level_q > LVL_W'(DEPTH)), "queue level beyond depth")

endmodule

FILE: src/pac_back.sv
// ----------------------------------------------------------------------------
// pac_back
// area and centroid from closed sums, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "polygon_area_centroid_assert.svh"

module pac_back #(
	parameter int COORD_BITS = pac_pkg::COORD_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	output logic              pop,
	input  pac_pkg::pac_sum_t pop_data,
	pac_result_if.source      result
);

	localparam int CROSS_W  = pac_pkg::CROSS_W;
	localparam int MOMENT_W = pac_pkg::MOMENT_W;
	localparam int AREA_W   = pac_pkg::AREA_W;
	localparam int DEN_W    = CROSS_W + 2;
	localparam int DIV_W    = DEN_W + COORD_BITS - 1;
	localparam int SAT_W    = DEN_W + COORD_BITS;
	localparam int CMP_W    = (MOMENT_W > SAT_W) ? MOMENT_W : SAT_W;
	localparam int STEP_W   = $clog2(COORD_BITS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ABS   = 3'd1;
	localparam logic [2:0] ST_SCALE = 3'd2;
	localparam logic [2:0] ST_SET   = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_NEXT  = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0] state_q;

	pac_pkg::pac_sum_t       sum_q;
	logic [CROSS_W-1:0]      acs_q;
	logic [MOMENT_W-1:0]     amx_q, amy_q, rem_q, mag;
	logic [DEN_W-1:0]        den_q;
	logic [DIV_W-1:0]        div_q;
	logic [AREA_W-1:0]       area_q;
	logic [COORD_BITS-1:0]   quo_q, cx_q, cy_q, coord;
	logic [STEP_W-1:0]       step_q;
	logic                    degen_q, sel_q, neg_q, sat_q;
	logic                    cs_neg, m_neg, ge, load_out;

	logic                    res_valid_q;
	logic [AREA_W-1:0]       area_o_q;
	logic [COORD_BITS-1:0]   cx_o_q, cy_o_q;
	logic                    degen_o_q;

	assign cs_neg   = sum_q.cs[CROSS_W-1];
	assign m_neg    = sel_q ? sum_q.my[MOMENT_W-1] : sum_q.mx[MOMENT_W-1];
	assign mag      = sel_q ? amy_q : amx_q;
	assign ge       = (CMP_W'(rem_q) >= CMP_W'(div_q));
	assign coord    = neg_q ? '0 : (sat_q ? '1 : quo_q);
	assign pop      = (state_q == ST_IDLE) && !empty;
	assign load_out = (state_q == ST_OUT) && (!res_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) state_q <= ST_ABS;
				end
				ST_ABS:   state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_SET;
				ST_SET:   state_q <= ST_DIV;
				ST_DIV: begin
					if (step_q == '0) state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					state_q <= sel_q ? ST_OUT : ST_SET;
				end
				ST_OUT: begin
					if (load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sum_q <= pop_data;
			end
			ST_ABS: begin
				acs_q <= cs_neg ? -sum_q.cs : sum_q.cs;
				amx_q <= sum_q.mx[MOMENT_W-1] ? -sum_q.mx : sum_q.mx;
				amy_q <= sum_q.my[MOMENT_W-1] ? -sum_q.my : sum_q.my;
			end
			ST_SCALE: begin
				den_q   <= DEN_W'({acs_q, 1'b0}) + DEN_W'(acs_q);
				degen_q <= sum_q.few || (acs_q == '0);
				area_q  <= (acs_q > CROSS_W'(pac_pkg::AREA_MAX)) ? pac_pkg::AREA_MAX
					: acs_q[AREA_W-1:0];
				sel_q   <= 1'b0;
			end
			ST_SET: begin
				rem_q  <= mag;
				div_q  <= DIV_W'(den_q) << (COORD_BITS - 1);
				sat_q  <= (CMP_W'(mag) >= (CMP_W'(den_q) << COORD_BITS));
				neg_q  <= (m_neg != cs_neg);
				quo_q  <= '0;
				step_q <= STEP_W'(COORD_BITS - 1);
			end
			ST_DIV: begin
				if (ge) rem_q <= rem_q - MOMENT_W'(div_q);
				quo_q  <= {quo_q[COORD_BITS-2:0], ge};
				div_q  <= div_q >> 1;
				step_q <= step_q - STEP_W'(1);
			end
			ST_NEXT: begin
				if (sel_q) begin
					cy_q <= coord;
				end else begin
					cx_q  <= coord;
					sel_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			area_o_q  <= degen_q ? '0 : area_q;
			cx_o_q    <= degen_q ? '0 : cx_q;
			cy_o_q    <= degen_q ? '0 : cy_q;
			degen_o_q <= degen_q;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.area_x2    = area_o_q;
	assign result.center_x   = cx_o_q;
	assign result.center_y   = cy_o_q;
	assign result.degenerate = degen_o_q;

	`PAC_CHECK(a_div_ends, ((state_q == ST_DIV) && (step_q == '0)) |=> (state_q == ST_NEXT), "divider overran")
	`PAC_CHECK(a_pop_starts, pop |=> (state_q == ST_ABS), "pop without start")
	`PAC_CHECK(a_degen_zero, (res_valid_q && degen_o_q) |-> ((area_o_q == '0) && (cx_o_q == '0) && (cy_o_q == '0)), "degenerate word not zeroed")

endmodule

FILE: src/polygon_area_centroid.sv
// ----------------------------------------------------------------------------
// polygon_area_centroid
// shoelace area and centroid of a polygon streamed in one vertex per word
// ----------------------------------------------------------------------------
// Vertices are taken one per cycle while vertex ready is high; a word with last
// set closes the polygon and yields one result word: twice the absolute area
// (saturated to 28 bits) and the centroid, moment over three times the signed
// cross sum, truncated toward zero and clamped to the coordinate range. Fewer
// than three vertices or zero area give degenerate with zeros. The front end
// is a four-stage multiply/accumulate pipeline that pushes to the queue. The
// back end takes one closed polygon at a time and has one shared divider that
// retires one quotient bit per cycle for x and then y. Up to QUEUE_DEPTH closed
// polygons wait between the two; polygons that arrive faster than the back end
// finishes them eventually hold vertex ready low until a queue slot frees.
// ----------------------------------------------------------------------------
module polygon_area_centroid #(
	parameter int COORD_BITS  = pac_pkg::COORD_BITS,
	parameter int QUEUE_DEPTH = pac_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	pac_vertex_if.sink   vertex,
	pac_result_if.source result
);

	logic              push, pop, q_full, q_empty;
	pac_pkg::pac_sum_t push_data, pop_data;

	pac_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vertex    (vertex),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	pac_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	pac_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.pop      (pop),
		.pop_data (pop_data),
		.result   (result)
	);

endmodule
